// ----- sv/integer_to_ascii_radix_formatter_macros.svh -----
// Assertion macros for the integer to ASCII radix formatter.
// Each macro samples on clk and is disabled while rst_n is low.
// Included by the modules that carry assertions; no other dependencies.
`ifndef INTEGER_TO_ASCII_RADIX_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_FORMATTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define I2A_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define I2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define I2A_ASSERT_IMPL(lbl, ante, cons, msg)
`define I2A_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- sv/i2a_pkg.sv -----
// Shared types, constants and character helpers for the radix formatter.
// No dependencies; imported by every module of the block.
package i2a_pkg;

  localparam int WORD_W    = 32;  // modes 0 and 1 operand
  localparam int PTR_W     = 64;  // mode 2 operand
  localparam int DIG_W     = 4;   // one stored digit
  localparam int DIG_MAX   = 32;  // longest digit string (radix 2)
  localparam int CNT_W     = 6;   // holds 0..DIG_MAX
  localparam int CHAR_W    = 8;
  localparam int RADIX_W   = 5;
  localparam int REG_IDX_W = 2;
  localparam int MAX_RADIX = 16;
  localparam int DIV_STEPS = 8;   // quotient bits per cycle
  localparam int CHUNKS    = WORD_W / DIV_STEPS;
  localparam int STEP_W    = 2;
  localparam int PFX_IDX_W = 3;
  localparam int STACK_W   = DIG_MAX * DIG_W;

  localparam logic [CNT_W-1:0]   DIG_MAX_CNT = CNT_W'(DIG_MAX);
  localparam logic [STEP_W-1:0]  LAST_CHUNK  = STEP_W'(CHUNKS - 1);
  localparam logic [RADIX_W-1:0] DEC_RADIX   = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] MIN_RADIX   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] TOP_RADIX   = RADIX_W'(MAX_RADIX);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = CHAR_W'(48);

  localparam logic [RADIX_W-1:0] RESET_RADIX   = RADIX_W'(10);
  localparam logic [PTR_W-1:0]   RESET_SYM_LO  = 64'h3736_3534_3332_3130; // "01234567"
  localparam logic [PTR_W-1:0]   RESET_SYM_HI  = 64'h6665_6463_6261_3938; // "89abcdef"

  typedef enum logic [1:0] {
    MODE_DEC    = 2'd0,
    MODE_SIGNED = 2'd1,
    MODE_PTR    = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RADIX  = 2'd0,
    REG_SYM_LO = 2'd1,
    REG_SYM_HI = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PFX_NONE  = 2'd0,
    PFX_MINUS = 2'd1,
    PFX_HEX   = 2'd2,
    PFX_NIL   = 2'd3
  } pfx_t;

  // controller -> datapath
  typedef struct packed {
    logic                 load;
    logic                 conv;
    logic                 last_chunk;
    logic                 emit_pfx;
    logic                 emit_dig;
    logic                 last;
    pfx_t                 pfx_kind;
    logic [PFX_IDX_W-1:0] pfx_idx;
  } i2a_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_zero;
    logic in_neg;
    logic conv_done;
    logic one_left;
  } i2a_sts_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] de;
    de = {{(CHAR_W-DIG_W){1'b0}}, d};
    if (d < DIG_W'(10)) begin
      hex_char = ASCII_ZERO + de;
    end else begin
      hex_char = 8'h57 + de;  // 'a' - 10
    end
  endfunction

  function automatic logic [CHAR_W-1:0] pfx_char(input pfx_t kind,
                                                 input logic [PFX_IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = 8'h00;
    unique case (kind)
      PFX_MINUS: c = "-";
      PFX_HEX:   c = (idx == 3'd0) ? "0" : "x";
      PFX_NIL: begin
        unique case (idx)
          3'd0:    c = "(";
          3'd1:    c = "n";
          3'd2:    c = "i";
          3'd3:    c = "l";
          default: c = ")";
        endcase
      end
      default:   c = 8'h00;
    endcase
    pfx_char = c;
  endfunction

endpackage

// ----- sv/i2a_regs.sv -----
// Configuration registers: radix and the two symbol table words.
// Depends on i2a_pkg; delivers the clamped radix to the datapath.
module i2a_regs
  import i2a_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [PTR_W-1:0]     cfg_data,
  output logic [RADIX_W-1:0]   eff_radix,
  output logic [PTR_W-1:0]     sym_lo,
  output logic [PTR_W-1:0]     sym_hi
);

  logic [RADIX_W-1:0] radix_r;
  logic [PTR_W-1:0]   sym_lo_r;
  logic [PTR_W-1:0]   sym_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= RESET_RADIX;
      sym_lo_r <= RESET_SYM_LO;
      sym_hi_r <= RESET_SYM_HI;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIX:  radix_r  <= cfg_data[RADIX_W-1:0];
        REG_SYM_LO: sym_lo_r <= cfg_data;
        REG_SYM_HI: sym_hi_r <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // clamp into 2..MAX_RADIX
  always_comb begin
    if (radix_r < MIN_RADIX) begin
      eff_radix = MIN_RADIX;
    end else if (radix_r > TOP_RADIX) begin
      eff_radix = TOP_RADIX;
    end else begin
      eff_radix = radix_r;
    end
  end

  assign sym_lo = sym_lo_r;
  assign sym_hi = sym_hi_r;

endmodule

// ----- sv/i2a_dpath.sv -----
// Datapath: operand register, 8-bit-per-cycle restoring divider, digit stack
// and output register. Depends on i2a_pkg and the assertion macro header.
`include "integer_to_ascii_radix_formatter_macros.svh"
module i2a_dpath
  import i2a_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_mode,
  input  logic [PTR_W-1:0]   in_value,
  input  i2a_cmd_t           cmd,
  input  logic [RADIX_W-1:0] eff_radix,
  input  logic [PTR_W-1:0]   sym_lo,
  input  logic [PTR_W-1:0]   sym_hi,
  output i2a_sts_t           sts,
  output logic               out_valid,
  output logic [CHAR_W-1:0]  out_character,
  output logic               out_last
);

  logic [PTR_W-1:0]   work_r;
  logic [DIG_W-1:0]   rem_r;
  logic [RADIX_W-1:0] div_r;
  mode_t              fmt_r;
  logic [STACK_W-1:0] stack_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;
  logic               out_last_r;
  logic [CHAR_W-1:0]  out_char_r;

  logic [WORD_W-1:0]  q_nxt;
  logic [DIG_W-1:0]   rem_nxt;
  logic [RADIX_W-1:0] trial;
  logic               qbit;
  logic               is_ptr;
  logic               push;
  logic [DIG_W-1:0]   push_dig;
  logic [WORD_W-1:0]  in_word;
  logic [WORD_W-1:0]  in_mag;
  logic [DIG_W-1:0]   top_dig;
  logic [CHAR_W-1:0]  dig_char;

  assign is_ptr  = (fmt_r == MODE_PTR);
  assign in_word = in_value[WORD_W-1:0];
  assign in_mag  = (mode_t'(in_mode) == MODE_SIGNED && in_word[WORD_W-1])
                   ? WORD_W'(0 - in_word) : in_word;

  // eight restoring steps; remainder stays below the divisor (<= 16)
  always_comb begin
    q_nxt   = work_r[WORD_W-1:0];
    rem_nxt = rem_r;
    trial   = '0;
    qbit    = 1'b0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem_nxt, q_nxt[WORD_W-1]};
      if (trial >= div_r) begin
        rem_nxt = DIG_W'(trial - div_r);
        qbit    = 1'b1;
      end else begin
        rem_nxt = trial[DIG_W-1:0];
        qbit    = 1'b0;
      end
      q_nxt = {q_nxt[WORD_W-2:0], qbit};
    end
  end

  assign push     = cmd.conv && (is_ptr || cmd.last_chunk);
  assign push_dig = is_ptr ? work_r[DIG_W-1:0] : rem_nxt;

  assign sts.in_zero   = (in_value == '0);
  assign sts.in_neg    = in_word[WORD_W-1];
  assign sts.conv_done = is_ptr ? (work_r[PTR_W-1:DIG_W] == '0)
                                : (cmd.last_chunk && q_nxt == '0);
  assign sts.one_left  = (cnt_r == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fmt_r  <= mode_t'(in_mode);
      div_r  <= (mode_t'(in_mode) == MODE_SIGNED) ? eff_radix : DEC_RADIX;
      rem_r  <= '0;
      work_r <= (mode_t'(in_mode) == MODE_PTR) ? in_value
                                                : {{(PTR_W-WORD_W){1'b0}}, in_mag};
    end else if (cmd.conv) begin
      if (is_ptr) begin
        work_r <= {{DIG_W{1'b0}}, work_r[PTR_W-1:DIG_W]};
      end else begin
        work_r <= {{(PTR_W-WORD_W){1'b0}}, q_nxt};
        rem_r  <= cmd.last_chunk ? '0 : rem_nxt;
      end
    end
  end

  // digit stack: newest (most significant) digit sits in the low nibble
  always_ff @(posedge clk) begin
    if (push) begin
      stack_r <= {stack_r[STACK_W-DIG_W-1:0], push_dig};
    end else if (cmd.emit_dig) begin
      stack_r <= {{DIG_W{1'b0}}, stack_r[STACK_W-1:DIG_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (push) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (cmd.emit_dig) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign top_dig = stack_r[DIG_W-1:0];

  always_comb begin
    unique case (fmt_r)
      MODE_DEC:    dig_char = ASCII_ZERO + {{(CHAR_W-DIG_W){1'b0}}, top_dig};
      MODE_SIGNED: dig_char = top_dig[DIG_W-1]
                              ? sym_hi[{top_dig[DIG_W-2:0], 3'b000} +: CHAR_W]
                              : sym_lo[{top_dig[DIG_W-2:0], 3'b000} +: CHAR_W];
      MODE_PTR:    dig_char = hex_char(top_dig);
      default:     dig_char = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_pfx || cmd.emit_dig;
      out_last_r  <= cmd.last && (cmd.emit_pfx || cmd.emit_dig);
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= cmd.emit_pfx ? pfx_char(cmd.pfx_kind, cmd.pfx_idx) : dig_char;
  end

  assign out_valid     = out_valid_r;
  assign out_last      = out_last_r;
  assign out_character = out_char_r;

  `I2A_ASSERT_IMPL(a_stack_no_overflow, push, cnt_r != DIG_MAX_CNT, "digit stack overflow")
  `I2A_ASSERT_IMPL(a_emit_nonempty, cmd.emit_dig, cnt_r != '0, "digit emitted from empty stack")
  `I2A_ASSERT_IMPL(a_last_has_strobe, out_last_r, out_valid_r, "last flag without strobe")

endmodule

// ----- sv/i2a_ctrl.sv -----
// Controller: sequences load, digit conversion, prefix and digit emission.
// Depends on i2a_pkg and the assertion macro header.
`include "integer_to_ascii_radix_formatter_macros.svh"
module i2a_ctrl
  import i2a_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_mode,
  input  i2a_sts_t   sts,
  output i2a_cmd_t   cmd,
  output logic       busy
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_PFX  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [PFX_IDX_W-1:0] pfx_idx_r, pfx_idx_nxt;
  pfx_t                 kind_r, kind_nxt;
  logic [PFX_IDX_W-1:0] pfx_end;

  always_comb begin
    unique case (kind_r)
      PFX_HEX: pfx_end = 3'd1;
      PFX_NIL: pfx_end = 3'd4;
      default: pfx_end = 3'd0;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    pfx_idx_nxt = pfx_idx_r;
    kind_nxt    = kind_r;
    cmd         = '0;
    cmd.pfx_kind   = kind_r;
    cmd.pfx_idx    = pfx_idx_r;
    cmd.last_chunk = (step_r == LAST_CHUNK);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (mode_t'(in_mode))
            MODE_DEC: begin
              kind_nxt  = PFX_NONE;
              state_nxt = S_CONV;
            end
            MODE_SIGNED: begin
              kind_nxt  = sts.in_neg ? PFX_MINUS : PFX_NONE;
              state_nxt = S_CONV;
            end
            MODE_PTR: begin
              kind_nxt  = sts.in_zero ? PFX_NIL : PFX_HEX;
              state_nxt = sts.in_zero ? S_PFX : S_CONV;
            end
            default: ;  // no output for this mode
          endcase
        end
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        step_nxt = step_r + STEP_W'(1);
        if (sts.conv_done) begin
          step_nxt  = '0;
          state_nxt = (kind_r == PFX_NONE) ? S_EMIT : S_PFX;
        end
      end
      S_PFX: begin
        cmd.emit_pfx = 1'b1;
        cmd.last     = (kind_r == PFX_NIL) && (pfx_idx_r == pfx_end);
        pfx_idx_nxt  = pfx_idx_r + PFX_IDX_W'(1);
        if (pfx_idx_r == pfx_end) begin
          pfx_idx_nxt = '0;
          state_nxt   = (kind_r == PFX_NIL) ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit_dig = 1'b1;
        cmd.last     = sts.one_left;
        if (sts.one_left) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      step_r    <= '0;
      pfx_idx_r <= '0;
      kind_r    <= PFX_NONE;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      pfx_idx_r <= pfx_idx_nxt;
      kind_r    <= kind_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `I2A_ASSERT_IMPL(a_step_conv_only, state_r != S_CONV, step_r == '0, "divider step outside conversion")
  `I2A_ASSERT_IMPL(a_pfx_idx_clear, state_r != S_PFX, pfx_idx_r == '0, "prefix index left non-zero")
  `I2A_ASSERT_NEXT(a_emit_done, (state_r == S_EMIT) && sts.one_left, state_r == S_IDLE, "emit did not finish")

endmodule

// ----- sv/integer_to_ascii_radix_formatter.sv -----
// Top level of the integer to ASCII radix formatter.
// Depends on i2a_pkg, i2a_regs, i2a_ctrl and i2a_dpath.
//
//  channel | ports                                  | transaction when
//  --------+----------------------------------------+----------------------------
//  input   | start, busy, in_mode, in_value         | start high and busy low
//  result  | out_valid, out_character, out_last     | every cycle out_valid is high
//  config  | cfg_we, cfg_index, cfg_data            | every cycle cfg_we is high
//
// One number at a time. Decimal and signed modes run each digit through the
//   shared restoring divider (8 quotient bits a cycle), then emit one character per
//   cycle. Pointer mode strips one hex digit a cycle; a zero pointer prints "(nil)".
// Characters appear the cycle after they are issued; busy falls with the last one.
// Reset (rst_n low, synchronous) restores radix 10 and the "0123456789abcdef" table.
// The receiver cannot stall: every strobe is one character, last marks the end.
module integer_to_ascii_radix_formatter
  import i2a_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_mode,
  input  logic [PTR_W-1:0]     in_value,
  output logic                 out_valid,
  output logic [CHAR_W-1:0]    out_character,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [PTR_W-1:0]     cfg_data
);

  i2a_cmd_t           cmd;
  i2a_sts_t           sts;
  logic [RADIX_W-1:0] eff_radix;
  logic [PTR_W-1:0]   sym_lo;
  logic [PTR_W-1:0]   sym_hi;

  // register file; writes must land only between transactions, the block does not enforce it
  i2a_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .eff_radix (eff_radix),
    .sym_lo    (sym_lo),
    .sym_hi    (sym_hi)
  );

  // sequencer: idle -> convert -> prefix (if any) -> emit digits, or idle -> prefix for "(nil)"
  i2a_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // divider, digit stack, character mapping and output register
  i2a_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .cmd           (cmd),
    .eff_radix     (eff_radix),
    .sym_lo        (sym_lo),
    .sym_hi        (sym_hi),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule
